>>> design/czn_pkg.sv
// shared constants and codes for the center zoom nearest neighbor block
package czn_pkg;

	localparam int POS_W       = 8;
	localparam int PIX_W       = 32;
	localparam int SCALE_W     = 24;
	localparam int SIZE_W      = 9;
	localparam int COORD_W     = 13;
	localparam int DIFF_W      = 11;
	localparam int FRAC_W      = 16;
	localparam int MAP_W       = 36;
	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_IDX_W   = 2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_W   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_H   = 2'd2;

	localparam logic [SCALE_W-1:0] RESET_SCALE = 24'd65536;
	localparam logic [SIZE_W-1:0]  RESET_SIZE  = 9'd256;
	localparam logic [MAP_W-1:0]   ROUND_HALF  = 36'd65536;

endpackage

>>> design/czn_front.sv
// front end: accepts items, maps read coordinates and builds queue entries
module czn_front
	import czn_pkg::*;
#(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	localparam int XW      = $clog2(MAX_WIDTH),
	localparam int YW      = $clog2(MAX_HEIGHT),
	localparam int AW      = XW + YW,
	localparam int ENTRY_W = 2 + AW + PIX_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic [POS_W-1:0]   pos_x,
	input  logic [POS_W-1:0]   pos_y,
	input  logic [PIX_W-1:0]   pixel_in,
	input  logic [SCALE_W-1:0] inverse_scale,
	input  logic [SIZE_W-1:0]  frame_width,
	input  logic [SIZE_W-1:0]  frame_height,
	output logic               push_valid,
	input  logic               push_ready,
	output logic [ENTRY_W-1:0] push_data
);

	localparam logic [COORD_W-1:0] MAX_W_C = COORD_W'(MAX_WIDTH);
	localparam logic [COORD_W-1:0] MAX_H_C = COORD_W'(MAX_HEIGHT);
	localparam int QW = MAP_W - 1 - (FRAC_W + 1);

	logic [SIZE_W-1:0]        w_eff, h_eff;
	logic [COORD_W-1:0]       px_ext, py_ext;
	logic signed [DIFF_W-1:0] diff_x, diff_y;
	logic signed [SCALE_W:0]  scale_s;
	logic signed [MAP_W-1:0]  prod_x, prod_y;
	logic [MAP_W-1:0]         off_x, off_y;
	logic                     wr_ok;
	logic                     adv1, adv2;

	logic                     v_s1;
	logic                     op_s1;
	logic                     wr_ok_s1;
	logic [XW-1:0]            col_s1;
	logic [YW-1:0]            row_s1;
	logic [PIX_W-1:0]         pix_s1;
	logic signed [MAP_W-1:0]  prod_x_s1, prod_y_s1;

	logic                     v_s2;
	logic                     op_s2;
	logic                     wr_ok_s2;
	logic [XW-1:0]            col_s2;
	logic [YW-1:0]            row_s2;
	logic [PIX_W-1:0]         pix_s2;
	logic [MAP_W-1:0]         sum_x_s2, sum_y_s2;

	logic                     inb_x, inb_y;
	logic [AW-1:0]            addr;

	// frame size clamped to the store
	assign w_eff = ({{(COORD_W-SIZE_W){1'b0}}, frame_width} > MAX_W_C) ?
		MAX_W_C[SIZE_W-1:0] : frame_width;
	assign h_eff = ({{(COORD_W-SIZE_W){1'b0}}, frame_height} > MAX_H_C) ?
		MAX_H_C[SIZE_W-1:0] : frame_height;

	assign px_ext = COORD_W'(pos_x);
	assign py_ext = COORD_W'(pos_y);
	assign wr_ok  = (px_ext < MAX_W_C) && (py_ext < MAX_H_C);

	// twice the offset from center, times the inverse scale
	assign diff_x  = $signed({2'b00, pos_x, 1'b0}) - $signed({2'b00, w_eff});
	assign diff_y  = $signed({2'b00, pos_y, 1'b0}) - $signed({2'b00, h_eff});
	assign scale_s = $signed({1'b0, inverse_scale});
	assign prod_x  = MAP_W'(diff_x) * MAP_W'(scale_s);
	assign prod_y  = MAP_W'(diff_y) * MAP_W'(scale_s);

	// center term plus half for rounding
	assign off_x = {{(MAP_W-SIZE_W-FRAC_W){1'b0}}, w_eff, {FRAC_W{1'b0}}} + ROUND_HALF;
	assign off_y = {{(MAP_W-SIZE_W-FRAC_W){1'b0}}, h_eff, {FRAC_W{1'b0}}} + ROUND_HALF;

	// rounded coordinate is sum >> 17, valid only when the sum is positive
	assign inb_x = !sum_x_s2[MAP_W-1] && (sum_x_s2 != '0) &&
		(sum_x_s2[MAP_W-2:FRAC_W+1] < QW'(w_eff));
	assign inb_y = !sum_y_s2[MAP_W-1] && (sum_y_s2 != '0) &&
		(sum_y_s2[MAP_W-2:FRAC_W+1] < QW'(h_eff));

	assign addr = (op_s2 == OP_READ) ?
		{sum_y_s2[FRAC_W+1 +: YW], sum_x_s2[FRAC_W+1 +: XW]} : {row_s2, col_s2};

	assign push_valid = v_s2 && ((op_s2 == OP_READ) || wr_ok_s2);
	assign push_data  = {op_s2, inb_x && inb_y, addr, pix_s2};

	assign adv2     = !v_s2 || !push_valid || push_ready;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			op_s1     <= opcode;
			wr_ok_s1  <= wr_ok;
			col_s1    <= px_ext[XW-1:0];
			row_s1    <= py_ext[YW-1:0];
			pix_s1    <= pixel_in;
			prod_x_s1 <= prod_x;
			prod_y_s1 <= prod_y;
		end
		if (adv2 && v_s1) begin
			op_s2    <= op_s1;
			wr_ok_s2 <= wr_ok_s1;
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			pix_s2   <= pix_s1;
			sum_x_s2 <= $unsigned(prod_x_s1) + off_x;
			sum_y_s2 <= $unsigned(prod_y_s1) + off_y;
		end
	end

endmodule

>>> design/czn_queue.sv
// short queue between the front end and the frame store
module czn_queue
	import czn_pkg::*;
#(
	parameter int DATA_W = 50
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [DATA_W-1:0] push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output logic [DATA_W-1:0] pop_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W:0] FULL_C = (PTR_W+1)'(QUEUE_DEPTH);

	logic [DATA_W-1:0] slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]    count_q;
	logic              push, pop;

	assign push_ready = (count_q != FULL_C);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slots_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_data;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_C)
		else $error("queue count above depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not grow on push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count did not shrink on pop");

endmodule

>>> design/czn_back.sv
// back end: frame store writes and reads, result register
module czn_back
	import czn_pkg::*;
#(
	parameter int AW = 16,
	localparam int ENTRY_W = 2 + AW + PIX_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  logic [ENTRY_W-1:0] pop_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PIX_W-1:0]   pixel_out,
	output logic               in_bounds
);

	localparam int MEM_DEPTH = 2 ** AW;

	logic [PIX_W-1:0] frame_mem [MEM_DEPTH];

	logic             is_read, inb;
	logic [AW-1:0]    addr;
	logic [PIX_W-1:0] pix;
	logic             pop, out_adv;

	logic             v_s1;
	logic             inb_s1;
	logic [PIX_W-1:0] rd_s1;

	logic             out_valid_q;
	logic             in_bounds_q;
	logic [PIX_W-1:0] pixel_q;

	assign is_read = pop_data[ENTRY_W-1];
	assign inb     = pop_data[ENTRY_W-2];
	assign addr    = pop_data[PIX_W +: AW];
	assign pix     = pop_data[PIX_W-1:0];

	assign out_adv   = !out_valid_q || out_ready;
	assign pop_ready = !v_s1 || out_adv;
	assign pop       = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (pop) begin
			if (is_read == OP_WRITE) begin
				frame_mem[addr] <= pix;
			end else begin
				rd_s1 <= frame_mem[addr];
			end
			inb_s1 <= inb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_ready) v_s1 <= pop_valid && (is_read == OP_READ);
			if (out_adv) out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && v_s1) begin
			pixel_q     <= inb_s1 ? rd_s1 : '0;
			in_bounds_q <= inb_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_q;
	assign in_bounds = in_bounds_q;

	a_oob_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !in_bounds_q |-> pixel_q == '0)
		else $error("out of frame result carries a pixel");

endmodule

>>> design/center_zoom_nearest_neighbor.sv
// top level: center zoom with nearest neighbor sampling over a stored frame
// a read item passes both front end stages, the queue and the memory read register into the result register
// sustained rate is one item per cycle, read or write, without output stalls
// path: multiply stage, add and bounds stage, four entry queue, memory read register, result register
// reset clears pipeline valids and the queue, and sets the configuration registers to their defaults
// the frame memory is not cleared; a pixel read before it is written is undefined
module center_zoom_nearest_neighbor
	import czn_pkg::*;
#(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SCALE_W-1:0]   cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 opcode,
	input  logic [POS_W-1:0]     pos_x,
	input  logic [POS_W-1:0]     pos_y,
	input  logic [PIX_W-1:0]     pixel_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PIX_W-1:0]     pixel_out,
	output logic                 in_bounds
);

	localparam int AW      = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);
	localparam int ENTRY_W = 2 + AW + PIX_W;

	logic [SCALE_W-1:0] inverse_scale_q;
	logic [SIZE_W-1:0]  frame_width_q, frame_height_q;

	logic               push_valid, push_ready;
	logic [ENTRY_W-1:0] push_data;
	logic               pop_valid, pop_ready;
	logic [ENTRY_W-1:0] pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_scale_q <= RESET_SCALE;
			frame_width_q   <= RESET_SIZE;
			frame_height_q  <= RESET_SIZE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INV_SCALE: inverse_scale_q <= cfg_data;
				REG_FRAME_W:   frame_width_q   <= cfg_data[SIZE_W-1:0];
				REG_FRAME_H:   frame_height_q  <= cfg_data[SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	czn_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pixel_in     (pixel_in),
		.inverse_scale(inverse_scale_q),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_data    (push_data)
	);

	czn_queue #(
		.DATA_W(ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	czn_back #(
		.AW(AW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_out(pixel_out),
		.in_bounds(in_bounds)
	);

endmodule
